// ===== rtl/lone_dot_line_stuffer_assert.svh =====
// ---------------------------------------------------------------------------
// lone_dot_line_stuffer assertion macros
// clocked property checks for the dot stuffer rtl
// ---------------------------------------------------------------------------
`ifndef LONE_DOT_LINE_STUFFER_ASSERT_SVH
`define LONE_DOT_LINE_STUFFER_ASSERT_SVH

// generic clocked check with explicit clock and reset
`define LDLS_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check on the block clock and reset
`define LDLS_ASSERT(label, prop, msg) \
  `LDLS_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/ldls_pkg.sv =====
// ---------------------------------------------------------------------------
// ldls_pkg
// shared constants and types of the lone dot line stuffer
// ---------------------------------------------------------------------------
package ldls_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxOut  = 4;
  localparam int unsigned CntW    = 3;

  localparam logic [ByteW-1:0] ChCr  = 8'h0D;
  localparam logic [ByteW-1:0] ChLf  = 8'h0A;
  localparam logic [ByteW-1:0] ChDot = 8'h2E;

  localparam logic DecodeModeReset = 1'b0;

  typedef struct packed {
    logic [1:0] held;
    logic       line_start;
    logic       prev_cr;
  } ldls_state_t;

  typedef struct packed {
    logic [MaxOut-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]              cnt;
    logic                         body_end;
  } ldls_group_t;

endpackage

// ===== rtl/ldls_step.sv =====
// ---------------------------------------------------------------------------
// ldls_step
// next-state and result group logic for one body byte
// ---------------------------------------------------------------------------
module ldls_step (
  input  logic                        decode_mode_i,
  input  ldls_pkg::ldls_state_t       state_i,
  input  logic [ldls_pkg::ByteW-1:0]  byte_i,
  input  logic                        last_i,
  output ldls_pkg::ldls_state_t       state_o,
  output ldls_pkg::ldls_group_t       group_o
);

  logic [1:0] dots;
  logic [1:0] full;

  assign dots = decode_mode_i ? 2'd2 : 2'd1;
  assign full = decode_mode_i ? 2'd3 : 2'd2;

  always_comb begin
    ldls_pkg::ldls_state_t st;
    ldls_pkg::ldls_group_t grp;
    logic [ldls_pkg::CntW-1:0] n;
    st  = state_i;
    grp = '0;
    n   = '0;

    if (state_i.held != 2'd0) begin
      if (state_i.held < dots && byte_i == ldls_pkg::ChDot) begin
        st.held = state_i.held + 2'd1;
      end else if (state_i.held == dots && byte_i == ldls_pkg::ChCr) begin
        st.held = state_i.held + 2'd1;
      end else if (state_i.held == full && byte_i == ldls_pkg::ChLf) begin
        if (decode_mode_i) begin
          grp.bytes[0] = ldls_pkg::ChDot;
          grp.bytes[1] = ldls_pkg::ChCr;
          grp.bytes[2] = ldls_pkg::ChLf;
          n = 3'd3;
        end else begin
          grp.bytes[0] = ldls_pkg::ChDot;
          grp.bytes[1] = ldls_pkg::ChDot;
          grp.bytes[2] = ldls_pkg::ChCr;
          grp.bytes[3] = ldls_pkg::ChLf;
          n = 3'd4;
        end
        st.held       = 2'd0;
        st.line_start = 1'b1;
        st.prev_cr    = 1'b0;
      end else begin
        // flush held bytes, then pass the breaking byte
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < state_i.held) begin
            grp.bytes[i] = (2'(i) < dots) ? ldls_pkg::ChDot : ldls_pkg::ChCr;
          end
        end
        grp.bytes[state_i.held] = byte_i;
        n             = {1'b0, state_i.held} + 3'd1;
        st.line_start = (state_i.held == full) && (byte_i == ldls_pkg::ChLf);
        st.prev_cr    = (byte_i == ldls_pkg::ChCr);
        st.held       = 2'd0;
      end
    end else if (state_i.line_start && byte_i == ldls_pkg::ChDot) begin
      st.held       = 2'd1;
      st.line_start = 1'b0;
      st.prev_cr    = 1'b0;
    end else begin
      grp.bytes[0]  = byte_i;
      n             = 3'd1;
      st.line_start = state_i.prev_cr && (byte_i == ldls_pkg::ChLf);
      st.prev_cr    = (byte_i == ldls_pkg::ChCr);
    end

    if (last_i) begin
      // held bytes only remain when nothing was emitted this step
      if (st.held != 2'd0) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < st.held) begin
            grp.bytes[i] = (2'(i) < dots) ? ldls_pkg::ChDot : ldls_pkg::ChCr;
          end
        end
        n = {1'b0, st.held};
      end
      st.held       = 2'd0;
      st.line_start = 1'b1;
      st.prev_cr    = 1'b0;
    end

    grp.cnt      = n;
    grp.body_end = last_i;
    state_o      = st;
    group_o      = grp;
  end

endmodule

// ===== rtl/ldls_ser.sv =====
// ---------------------------------------------------------------------------
// ldls_ser
// result group register, shifts out one byte per word
// ---------------------------------------------------------------------------
module ldls_ser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  ldls_pkg::ldls_group_t       group_i,
  output logic                        free_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // out_byte
  output logic                        m_axis_tlast,  // run_last
  output logic                        m_axis_tuser   // body_end
);

  logic [ldls_pkg::MaxOut-1:0][ldls_pkg::ByteW-1:0] bytes_q, bytes_d;
  logic [ldls_pkg::CntW-1:0] rem_q, rem_d;
  logic                      end_q, end_d;
  logic                      emit;

  assign emit   = m_axis_tvalid && m_axis_tready;
  assign free_o = (rem_q == '0) || (rem_q == 3'd1 && m_axis_tready);

  always_comb begin
    bytes_d = bytes_q;
    rem_d   = rem_q;
    end_d   = end_q;
    if (load_i) begin
      bytes_d = group_i.bytes;
      rem_d   = group_i.cnt;
      end_d   = group_i.body_end;
    end else if (emit) begin
      bytes_d = {ldls_pkg::ByteW'(0), bytes_q[ldls_pkg::MaxOut-1:1]};
      rem_d   = rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    end_q   <= end_d;
  end

  assign m_axis_tvalid = (rem_q != '0);
  assign m_axis_tdata  = bytes_q[0];
  assign m_axis_tlast  = (rem_q == 3'd1);
  assign m_axis_tuser  = (rem_q == 3'd1) && end_q;

endmodule

// ===== rtl/lone_dot_line_stuffer.sv =====
// ---------------------------------------------------------------------------
// lone_dot_line_stuffer
// stuffs lone-dot lines or unstuffs double-dot lines of a mail body
// ---------------------------------------------------------------------------
// channel  dir  tdata      tlast      tuser
// s_axis   in   body_byte  body_last  -
// m_axis   out  out_byte   run_last   body_end
// cfg      in   decode_mode (write enable, no index)
//
// one byte enters per cycle while the result register is free; a byte passes the input
// register and then the result register; a byte that expands to n words (n up to 4) stalls
// the input while the result register drains one word per cycle, when m_axis_tready is high
// reset is asynchronous, active low; no clearing pass
// ---------------------------------------------------------------------------
`include "lone_dot_line_stuffer_assert.svh"

module lone_dot_line_stuffer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,   // decode_mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // body_byte
  input  logic       s_axis_tlast,  // body_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // out_byte
  output logic       m_axis_tlast,  // run_last
  output logic       m_axis_tuser   // body_end
);

  logic                        mode_q;
  logic                        in_vld_q, in_vld_d;
  logic [ldls_pkg::ByteW-1:0]  in_byte_q;
  logic                        in_last_q;
  ldls_pkg::ldls_state_t       st_q, st_d, st_nx;
  ldls_pkg::ldls_group_t       grp;
  logic                        free;
  logic                        adv;
  logic                        load;
  logic                        s_hs;

  ldls_step u_step (
    .decode_mode_i (mode_q),
    .state_i       (st_q),
    .byte_i        (in_byte_q),
    .last_i        (in_last_q),
    .state_o       (st_nx),
    .group_o       (grp)
  );

  assign adv           = in_vld_q && ((grp.cnt == '0) || free);
  assign load          = adv && (grp.cnt != '0);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_hs          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    st_d     = st_q;
    if (adv) begin
      in_vld_d = 1'b0;
      st_d     = st_nx;
    end
    if (s_hs) begin
      in_vld_d = 1'b1;
    end
    if (cfg_we_i) begin
      st_d = '{held: 2'd0, line_start: 1'b1, prev_cr: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ldls_pkg::DecodeModeReset;
      in_vld_q <= 1'b0;
      st_q     <= '{held: 2'd0, line_start: 1'b1, prev_cr: 1'b0};
    end else begin
      in_vld_q <= in_vld_d;
      st_q     <= st_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  ldls_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .group_i       (grp),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  `LDLS_ASSERT(a_held_bound, (st_q.held != 2'd3) || mode_q, "encode holds at most two bytes")
  `LDLS_ASSERT(a_start_no_held, st_q.line_start |-> (st_q.held == 2'd0), "start with held")
  `LDLS_ASSERT(a_stall_keeps, (in_vld_q && !adv) |=> in_vld_q, "stalled byte dropped")
  `LDLS_ASSERT(a_last_resets, (adv && in_last_q && !cfg_we_i) |=> st_q.line_start, "body end did not reset")

endmodule
